@@ hw/rtl/ecpu_pkg.sv @@
// Shared types and codes for the eight-bit processor ALU with flags.
package ecpu_pkg;

   typedef enum logic [4:0] {
      KIND_ADD8     = 5'd0,
      KIND_SUB8     = 5'd1,
      KIND_INC8     = 5'd2,
      KIND_DEC8     = 5'd3,
      KIND_CMP8     = 5'd4,
      KIND_AND8     = 5'd5,
      KIND_XOR8     = 5'd6,
      KIND_OR8      = 5'd7,
      KIND_DAA      = 5'd8,
      KIND_ADD16    = 5'd9,
      KIND_ADC16    = 5'd10,
      KIND_SBC16    = 5'd11,
      KIND_RL_CARRY = 5'd12,
      KIND_RL_CIRC  = 5'd13,
      KIND_SH_LOGIC = 5'd14,
      KIND_SH_ARITH = 5'd15,
      KIND_FAST_RC  = 5'd16,
      KIND_FAST_RCC = 5'd17
   } kind_type;

   localparam int unsigned FL_C  = 0;
   localparam int unsigned FL_N  = 1;
   localparam int unsigned FL_PV = 2;
   localparam int unsigned FL_H  = 4;
   localparam int unsigned FL_Z  = 6;
   localparam int unsigned FL_S  = 7;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic        carry_bit;
      logic [7:0]  flags_in;
      logic        shift_left;
   } req_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic [7:0]  flags_out;
   } rsp_type;

endpackage

@@ hw/rtl/ecpu_alu.sv @@
// Combinational ALU datapath that computes the result and flag byte of one request.
module ecpu_alu
   import ecpu_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   localparam logic [1:0] MODE_CARRY = 2'd0;
   localparam logic [1:0] MODE_CIRC  = 2'd1;
   localparam logic [1:0] MODE_LOGIC = 2'd2;
   localparam logic [1:0] MODE_ARITH = 2'd3;

   kind_type    kind;
   logic [7:0]  a;
   logic [7:0]  b;
   logic [7:0]  f;
   logic        c;

   logic        b_invert;
   logic [7:0]  add_b;
   logic        add_cin;
   logic [8:0]  add_sum;
   logic [4:0]  add_half;
   logic [7:0]  add_r;
   logic        add_v;

   logic [15:0] w_b;
   logic        w_cin;
   logic [16:0] w_sum;
   logic [12:0] w_half;
   logic [15:0] w_r;
   logic        w_v;

   logic [7:0]  inc_r;
   logic [7:0]  dec_r;
   logic [7:0]  and_r;
   logic [7:0]  xor_r;
   logic [7:0]  or_r;

   logic        daa_lo;
   logic        daa_above;
   logic        daa_hi;
   logic [7:0]  daa_adj;
   logic [7:0]  daa_r;

   logic [1:0]  sh_mode;
   logic        sh_cout;
   logic        sh_fill;
   logic [7:0]  sh_r;

   logic [15:0] val;
   logic [7:0]  fl;

   assign kind = kind_type'(req.kind);
   assign a    = req.operand_a[7:0];
   assign b    = req.operand_b[7:0];
   assign f    = req.flags_in;
   assign c    = req.carry_bit;

   // The byte adder serves add, subtract and compare.
   assign b_invert = (kind == KIND_SUB8) || (kind == KIND_CMP8);
   assign add_b    = b_invert ? ~b : b;
   assign add_cin  = (kind == KIND_ADD8) ? c : ((kind == KIND_SUB8) ? ~c : 1'b1);
   assign add_sum  = {1'b0, a} + {1'b0, add_b} + {8'd0, add_cin};
   assign add_half = {1'b0, a[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
   assign add_r    = add_sum[7:0];
   assign add_v    = (a[7] ^ add_r[7]) & (add_b[7] ^ add_r[7]);

   // The word adder serves the three 16-bit operations.
   assign w_b    = (kind == KIND_SBC16) ? ~req.operand_b : req.operand_b;
   assign w_cin  = (kind == KIND_ADD16) ? 1'b0 : ((kind == KIND_SBC16) ? ~c : c);
   assign w_sum  = {1'b0, req.operand_a} + {1'b0, w_b} + {16'd0, w_cin};
   assign w_half = {1'b0, req.operand_a[11:0]} + {1'b0, w_b[11:0]} + {12'd0, w_cin};
   assign w_r    = w_sum[15:0];
   assign w_v    = (req.operand_a[15] ^ w_r[15]) & (w_b[15] ^ w_r[15]);

   assign inc_r = a + 8'd1;
   assign dec_r = a - 8'd1;
   assign and_r = a & b;
   assign xor_r = a ^ b;
   assign or_r  = a | b;

   assign daa_lo    = (a[3:0] > 4'h9) || f[FL_H];
   assign daa_above = a > 8'h99;
   assign daa_hi    = daa_above || f[FL_C];
   assign daa_adj   = {1'b0, daa_hi, daa_hi, 2'b00, daa_lo, daa_lo, 1'b0};
   assign daa_r     = f[FL_N] ? (a - daa_adj) : (a + daa_adj);

   // Both the prefixed and the fast rotates take their mode from the low selector bits.
   assign sh_mode = req.kind[1:0];
   assign sh_cout = req.shift_left ? a[7] : a[0];

   always_comb begin
      case (sh_mode)
         MODE_CARRY: sh_fill = f[FL_C];
         MODE_CIRC:  sh_fill = sh_cout;
         MODE_LOGIC: sh_fill = 1'b0;
         MODE_ARITH: sh_fill = req.shift_left ? 1'b0 : a[7];
         default:    sh_fill = 1'b0;
      endcase
   end

   assign sh_r = req.shift_left ? {a[6:0], sh_fill} : {sh_fill, a[7:1]};

   always_comb begin
      val = 16'd0;
      fl  = f;
      case (kind)
         KIND_ADD8: begin
            val = {8'd0, add_r};
            fl  = {add_r[7], add_r == 8'd0, add_r[5], add_half[4], add_r[3], add_v, 1'b0,
                   add_sum[8]};
         end
         KIND_SUB8: begin
            val = {8'd0, add_r};
            fl  = {add_r[7], add_r == 8'd0, add_r[5], ~add_half[4], add_r[3], add_v, 1'b1,
                   ~add_sum[8]};
         end
         KIND_CMP8: begin
            val = {8'd0, add_r};
            fl  = {add_r[7], add_r == 8'd0, b[5], ~add_half[4], b[3], add_v, 1'b1,
                   ~add_sum[8]};
         end
         KIND_INC8: begin
            val = {8'd0, inc_r};
            fl  = {inc_r[7], inc_r == 8'd0, inc_r[5], inc_r[4] ^ a[4], inc_r[3], a == 8'h7f,
                   1'b0, f[FL_C]};
         end
         KIND_DEC8: begin
            val = {8'd0, dec_r};
            fl  = {dec_r[7], dec_r == 8'd0, dec_r[5], dec_r[4] ^ a[4], dec_r[3], a == 8'h80,
                   1'b1, f[FL_C]};
         end
         KIND_AND8: begin
            val = {8'd0, and_r};
            fl  = {and_r[7], and_r == 8'd0, and_r[5], 1'b1, and_r[3], ~^and_r, 2'b00};
         end
         KIND_XOR8: begin
            val = {8'd0, xor_r};
            fl  = {xor_r[7], xor_r == 8'd0, xor_r[5], 1'b0, xor_r[3], ~^xor_r, 2'b00};
         end
         KIND_OR8: begin
            val = {8'd0, or_r};
            fl  = {or_r[7], or_r == 8'd0, or_r[5], 1'b0, or_r[3], ~^or_r, 2'b00};
         end
         KIND_DAA: begin
            val = {8'd0, daa_r};
            fl  = {daa_r[7], daa_r == 8'd0, daa_r[5], a[4] ^ daa_r[4], daa_r[3], ~^daa_r,
                   f[FL_N], daa_above | f[FL_C]};
         end
         KIND_ADD16: begin
            val = w_r;
            fl  = {f[FL_S], f[FL_Z], w_r[13], w_half[12], w_r[11], f[FL_PV], 1'b0, w_sum[16]};
         end
         KIND_ADC16: begin
            val = w_r;
            fl  = {w_r[15], w_r == 16'd0, w_r[13], w_half[12], w_r[11], w_v, 1'b0, w_sum[16]};
         end
         KIND_SBC16: begin
            val = w_r;
            fl  = {w_r[15], w_r == 16'd0, w_r[13], ~w_half[12], w_r[11], w_v, 1'b1,
                   ~w_sum[16]};
         end
         KIND_RL_CARRY, KIND_RL_CIRC, KIND_SH_LOGIC, KIND_SH_ARITH: begin
            val = {8'd0, sh_r};
            fl  = {sh_r[7], sh_r == 8'd0, sh_r[5], 1'b0, sh_r[3], ~^sh_r, 1'b0, sh_cout};
         end
         KIND_FAST_RC, KIND_FAST_RCC: begin
            val = {8'd0, sh_r};
            fl  = {f[FL_S], f[FL_Z], sh_r[5], 1'b0, sh_r[3], f[FL_PV], 1'b0, sh_cout};
         end
         default: begin
            val = 16'd0;
            fl  = f;
         end
      endcase
   end

   assign rsp.result_value = val;
   assign rsp.flags_out    = fl;

endmodule

@@ hw/rtl/eight_bit_cpu_alu_with_flags.sv @@
// Top level of the eight-bit processor ALU with an input register and a result register.
// A request passes the input register and then the result register on its way to rsp_.
// Throughput is one request per cycle while the output is not stalled; a new request is
// taken while a finished result waits only if the input register is empty.
// Synchronous reset clears both valid flags; the payload registers are not reset.
module eight_bit_cpu_alu_with_flags
   import ecpu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_kind,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   input  logic        req_carry_bit,
   input  logic [7:0]  req_flags_in,
   input  logic        req_shift_left,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_value,
   output logic [7:0]  rsp_flags_out
);

   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_advance;
   logic    req_advance;

   assign rsp_advance = !rsp_valid_ff || !rsp_stall;
   assign req_advance = !req_valid_ff || rsp_advance;
   assign req_stall   = !req_advance;

   assign req_in = '{kind:       req_kind,
                     operand_a:  req_operand_a,
                     operand_b:  req_operand_b,
                     carry_bit:  req_carry_bit,
                     flags_in:   req_flags_in,
                     shift_left: req_shift_left};

   ecpu_alu u_alu (
      .req (req_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_advance) begin
            req_valid_ff <= req_valid;
         end
         if (rsp_advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_advance && req_valid) begin
         req_ff <= req_in;
      end
      if (rsp_advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_ff.result_value;
   assign rsp_flags_out    = rsp_ff.flags_out;

`ifndef SYNTHESIS
   // An accepted request always lands in the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_valid_ff)
   else $error("accepted request not captured in input register");

   // A held request moves to a free result register in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
   else $error("request did not advance into free result register");

   // The input side stalls only when both registers are full and the output is stalled.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff && rsp_stall))
   else $error("input stalled while the pipeline had room");
`endif

endmodule
